// ===== rtl/core/homogeneous_vertex_transform_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the homogeneous vertex transform
// Concurrent checks clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_ASSERT_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define HVT_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Antecedent implies consequent in the following cycle.
`define HVT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HVT_ASSERT_IMPLY(lbl, ante, cons, msg)
`define HVT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/hvt_pkg.sv =====
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared constants and types of the homogeneous vertex transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

   localparam int FRAC_BITS_DEF  = 8;
   localparam int COMP_WIDTH_DEF = 16;

   localparam int FIELD_W  = 16;
   localparam int NUM_COLS = 4;
   localparam int NUM_ROWS = 4;
   localparam int ROW_W    = NUM_COLS * FIELD_W;
   localparam int PROD_W   = 2 * FIELD_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int MAG_W    = SUM_W - 1;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW0 = 2'd0,
      CSR_ROW1 = 2'd1,
      CSR_ROW2 = 2'd2,
      CSR_ROW3 = 2'd3
   } csr_index_type;

   // Identity matrix after reset.
   localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
   localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
   localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
   localparam logic [ROW_W-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;

   // Result of one divider lane.
   typedef struct packed {
      logic               neg;
      logic               ovf;
      logic [FIELD_W-1:0] quo;
   } div_res_type;

   // Side information that travels next to the divider lanes.
   typedef struct packed {
      logic                             divided;
      logic                             pass_sat;
      logic [NUM_ROWS-1:0][FIELD_W-1:0] pass_val;
   } side_type;

endpackage

// ===== rtl/core/hvt_lane.sv =====
// ----------------------------------------------------------------------------
// hvt_lane
// One row dot product: four multipliers, registered, then a registered sum.
// ----------------------------------------------------------------------------
module hvt_lane (
   input  logic                                              clock,
   input  logic                                              advance,
   input  logic [hvt_pkg::ROW_W-1:0]                         coeffs,
   input  logic [hvt_pkg::NUM_COLS-1:0][hvt_pkg::FIELD_W-1:0] vec,
   output logic signed [hvt_pkg::SUM_W-1:0]                  sum
);

   logic signed [hvt_pkg::PROD_W-1:0] prod_in [hvt_pkg::NUM_COLS];
   logic signed [hvt_pkg::PROD_W-1:0] prod_ff [hvt_pkg::NUM_COLS];
   logic signed [hvt_pkg::SUM_W-1:0]  sum_in;
   logic signed [hvt_pkg::SUM_W-1:0]  sum_ff;

   // Exact products of coefficient and component.
   always_comb begin
      for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
         prod_in[c] = $signed(coeffs[c*hvt_pkg::FIELD_W +: hvt_pkg::FIELD_W])
                    * $signed(vec[c]);
      end
   end

   // Exact sum at twice the fraction bits.
   assign sum_in = hvt_pkg::SUM_W'(prod_ff[0]) + hvt_pkg::SUM_W'(prod_ff[1])
                 + hvt_pkg::SUM_W'(prod_ff[2]) + hvt_pkg::SUM_W'(prod_ff[3]);

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== rtl/core/hvt_div.sv =====
// ----------------------------------------------------------------------------
// hvt_div
// Pipelined restoring divider: an overflow check, then one quotient bit
// per stage, most significant first.
// ----------------------------------------------------------------------------
module hvt_div #(
   parameter int FRAC_BITS       = hvt_pkg::FRAC_BITS_DEF,
   parameter int COMPONENT_WIDTH = hvt_pkg::COMP_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic [hvt_pkg::MAG_W+FRAC_BITS-1:0]   num,
   input  logic [hvt_pkg::MAG_W-1:0]             den,
   input  logic                                  neg,
   output hvt_pkg::div_res_type                  res
);

   localparam int NUM_W  = hvt_pkg::MAG_W + FRAC_BITS;
   localparam int DSH_W  = hvt_pkg::MAG_W + COMPONENT_WIDTH;
   localparam int CMP_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;
   localparam int STAGES = COMPONENT_WIDTH + 1;

   logic [CMP_W-1:0]           rem_ff [STAGES];
   logic [hvt_pkg::MAG_W-1:0]  den_ff [STAGES];
   logic [COMPONENT_WIDTH-1:0] quo_ff [STAGES];
   logic                       ovf_ff [STAGES];
   logic                       neg_ff [STAGES];
   logic                       ovf_in;

   // First stage: the quotient does not fit when num >= den * 2^width.
   assign ovf_in = CMP_W'(num) >= (CMP_W'(den) << COMPONENT_WIDTH);

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= CMP_W'(num);
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= ovf_in;
         neg_ff[0] <= neg;
      end
   end

   // One compare and subtract per stage.
   for (genvar k = 1; k < STAGES; k++) begin : g_stage
      localparam int BIT = COMPONENT_WIDTH - k;
      logic [CMP_W-1:0]           trial;
      logic                       fits;
      logic [CMP_W-1:0]           rem_in;
      logic [COMPONENT_WIDTH-1:0] quo_in;

      always_comb begin
         trial  = CMP_W'(den_ff[k-1]) << BIT;
         fits   = rem_ff[k-1] >= trial;
         rem_in = fits ? (rem_ff[k-1] - trial) : rem_ff[k-1];
         quo_in = quo_ff[k-1];
         quo_in[BIT] = fits;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= quo_in;
            ovf_ff[k] <= ovf_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   assign res.neg = neg_ff[STAGES-1];
   assign res.ovf = ovf_ff[STAGES-1];
   assign res.quo = hvt_pkg::FIELD_W'(quo_ff[STAGES-1]);

endmodule

// ===== rtl/core/homogeneous_vertex_transform.sv =====
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// 4x4 matrix times homogeneous vector in signed fixed point, with a
// perspective divide by the w product when it is nonzero.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_valid/req_ready  | req_in_x, req_in_y, req_in_z, req_in_w
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_out_x..w, rsp_was_divided, rsp_saturated
//  csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// One item is accepted per cycle while the output is not stalled. The divider
// lanes resolve one quotient bit per stage after two multiply/sum stages and
// one preparation stage.
// The whole pipeline advances whenever the output register is empty or its
// result is being taken; a stalled output holds every stage in place.
// Reset clears the valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform #(
   parameter int FRAC_BITS       = hvt_pkg::FRAC_BITS_DEF,
   parameter int COMPONENT_WIDTH = hvt_pkg::COMP_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [hvt_pkg::FIELD_W-1:0]  req_in_x,
   input  logic signed [hvt_pkg::FIELD_W-1:0]  req_in_y,
   input  logic signed [hvt_pkg::FIELD_W-1:0]  req_in_z,
   input  logic signed [hvt_pkg::FIELD_W-1:0]  req_in_w,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [hvt_pkg::FIELD_W-1:0]  rsp_out_x,
   output logic signed [hvt_pkg::FIELD_W-1:0]  rsp_out_y,
   output logic signed [hvt_pkg::FIELD_W-1:0]  rsp_out_z,
   output logic signed [hvt_pkg::FIELD_W-1:0]  rsp_out_w,
   output logic                                rsp_was_divided,
   output logic                                rsp_saturated,
   input  logic                                csr_wr_en,
   input  logic [hvt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hvt_pkg::ROW_W-1:0]           csr_wdata
);

`include "homogeneous_vertex_transform_assert.svh"

   localparam int NUM_W   = hvt_pkg::MAG_W + FRAC_BITS;
   localparam int STAGES  = COMPONENT_WIDTH + 1;
   localparam int PIPE_D  = 3 + STAGES;
   localparam int QS_W    = hvt_pkg::FIELD_W + 1;
   localparam int NUM_DIV = hvt_pkg::NUM_ROWS - 1;

   localparam logic signed [hvt_pkg::SUM_W-1:0] SUM_HI =
      hvt_pkg::SUM_W'((64'sd1 <<< (COMPONENT_WIDTH - 1)) - 64'sd1);
   localparam logic signed [hvt_pkg::SUM_W-1:0] SUM_LO =
      hvt_pkg::SUM_W'(-(64'sd1 <<< (COMPONENT_WIDTH - 1)));
   localparam logic signed [QS_W-1:0] QS_HI = QS_W'(SUM_HI);
   localparam logic signed [QS_W-1:0] QS_LO = QS_W'(SUM_LO);
   localparam logic ONE_SAT = (FRAC_BITS >= COMPONENT_WIDTH - 1);
   localparam logic [hvt_pkg::FIELD_W-1:0] ONE_VAL = ONE_SAT ?
      hvt_pkg::FIELD_W'(SUM_HI) : hvt_pkg::FIELD_W'(64'd1 << FRAC_BITS);

   logic advance;
   logic [hvt_pkg::ROW_W-1:0] row_ff [hvt_pkg::NUM_ROWS];
   logic [PIPE_D-1:0] vld_ff;
   logic [hvt_pkg::NUM_COLS-1:0][hvt_pkg::FIELD_W-1:0] vec;
   logic signed [hvt_pkg::SUM_W-1:0] sum [hvt_pkg::NUM_ROWS];

   // Preparation stage signals.
   logic [hvt_pkg::MAG_W-1:0] mag [hvt_pkg::NUM_ROWS];
   logic [NUM_W-1:0]          num_in [NUM_DIV];
   logic [NUM_W-1:0]          num_ff [NUM_DIV];
   logic                      neg_in [NUM_DIV];
   logic                      neg_ff [NUM_DIV];
   logic [hvt_pkg::MAG_W-1:0] den_ff;
   hvt_pkg::side_type         prep_in;
   hvt_pkg::side_type         prep_ff;
   hvt_pkg::side_type         side_ff [STAGES];
   hvt_pkg::div_res_type      div_res [NUM_DIV];

   // Merge stage signals.
   logic [hvt_pkg::NUM_ROWS-1:0][hvt_pkg::FIELD_W-1:0] out_val;
   logic                                             sat_in;

   logic signed [hvt_pkg::FIELD_W-1:0] rsp_out_x_ff, rsp_out_y_ff;
   logic signed [hvt_pkg::FIELD_W-1:0] rsp_out_z_ff, rsp_out_w_ff;
   logic rsp_was_divided_ff, rsp_saturated_ff, rsp_valid_ff;

   // Global advance: the output register is free or being emptied.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= hvt_pkg::ROW0_RESET;
         row_ff[1] <= hvt_pkg::ROW1_RESET;
         row_ff[2] <= hvt_pkg::ROW2_RESET;
         row_ff[3] <= hvt_pkg::ROW3_RESET;
      end else if (csr_wr_en) begin
         case (hvt_pkg::csr_index_type'(csr_index))
            hvt_pkg::CSR_ROW0: row_ff[0] <= csr_wdata;
            hvt_pkg::CSR_ROW1: row_ff[1] <= csr_wdata;
            hvt_pkg::CSR_ROW2: row_ff[2] <= csr_wdata;
            hvt_pkg::CSR_ROW3: row_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Valid bits of every pipeline stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[PIPE_D-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_D-1];
      end
   end

   // One dot-product lane per matrix row.
   assign vec = {req_in_w, req_in_z, req_in_y, req_in_x};

   for (genvar r = 0; r < hvt_pkg::NUM_ROWS; r++) begin : g_lane
      hvt_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .coeffs  (row_ff[r]),
         .vec     (vec),
         .sum     (sum[r])
      );
   end

   // Preparation: magnitudes for the dividers, and the pass-through values
   // scaled toward minus infinity and clamped.
   always_comb begin
      logic signed [hvt_pkg::SUM_W-1:0] shifted;
      logic signed [hvt_pkg::SUM_W-1:0] clamped;
      prep_in.divided  = (sum[3] != '0);
      prep_in.pass_sat = 1'b0;
      for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
         mag[r]  = hvt_pkg::MAG_W'(sum[r][hvt_pkg::SUM_W-1] ? -sum[r] : sum[r]);
         shifted = sum[r] >>> FRAC_BITS;
         clamped = shifted;
         if (shifted > SUM_HI) begin
            clamped = SUM_HI;
            prep_in.pass_sat = 1'b1;
         end else if (shifted < SUM_LO) begin
            clamped = SUM_LO;
            prep_in.pass_sat = 1'b1;
         end
         prep_in.pass_val[r] = hvt_pkg::FIELD_W'(clamped);
      end
      for (int r = 0; r < NUM_DIV; r++) begin
         num_in[r] = {mag[r], {FRAC_BITS{1'b0}}};
         neg_in[r] = sum[r][hvt_pkg::SUM_W-1] ^ sum[3][hvt_pkg::SUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff  <= num_in;
         neg_ff  <= neg_in;
         den_ff  <= mag[3];
         prep_ff <= prep_in;
      end
   end

   // Divider lanes for x, y and z.
   for (genvar r = 0; r < NUM_DIV; r++) begin : g_div
      hvt_div #(
         .FRAC_BITS       (FRAC_BITS),
         .COMPONENT_WIDTH (COMPONENT_WIDTH)
      ) u_div (
         .clock   (clock),
         .advance (advance),
         .num     (num_ff[r]),
         .den     (den_ff),
         .neg     (neg_ff[r]),
         .res     (div_res[r])
      );
   end

   // Side information delayed to line up with the divider results.
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= prep_ff;
         for (int k = 1; k < STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Merge: sign and clamp the quotients, or pick the pass-through values.
   always_comb begin
      logic signed [QS_W-1:0] qs;
      logic                   div_sat;
      div_sat = ONE_SAT;
      for (int r = 0; r < NUM_DIV; r++) begin
         qs = div_res[r].neg ? -$signed({1'b0, div_res[r].quo})
                             :  $signed({1'b0, div_res[r].quo});
         if (div_res[r].ovf) begin
            qs      = div_res[r].neg ? QS_LO : QS_HI;
            div_sat = 1'b1;
         end else if (qs > QS_HI) begin
            qs      = QS_HI;
            div_sat = 1'b1;
         end else if (qs < QS_LO) begin
            qs      = QS_LO;
            div_sat = 1'b1;
         end
         out_val[r] = side_ff[STAGES-1].divided ? hvt_pkg::FIELD_W'(qs)
                                                : side_ff[STAGES-1].pass_val[r];
      end
      out_val[3] = side_ff[STAGES-1].divided ? ONE_VAL : side_ff[STAGES-1].pass_val[3];
      sat_in     = side_ff[STAGES-1].divided ? div_sat : side_ff[STAGES-1].pass_sat;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_out_x_ff       <= out_val[0];
         rsp_out_y_ff       <= out_val[1];
         rsp_out_z_ff       <= out_val[2];
         rsp_out_w_ff       <= out_val[3];
         rsp_was_divided_ff <= side_ff[STAGES-1].divided;
         rsp_saturated_ff   <= sat_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_out_x_ff;
   assign rsp_out_y       = rsp_out_y_ff;
   assign rsp_out_z       = rsp_out_z_ff;
   assign rsp_out_w       = rsp_out_w_ff;
   assign rsp_was_divided = rsp_was_divided_ff;
   assign rsp_saturated   = rsp_saturated_ff;

   // An accepted item enters the first stage.
   `HVT_ASSERT_NEXT(a_enter, req_valid && req_ready, vld_ff[0], "accepted item lost at entry")
   // Without a divide the w sum was zero, so w must read zero.
   `HVT_ASSERT_IMPLY(a_pass_w, rsp_valid_ff && !rsp_was_divided_ff, rsp_out_w_ff == '0, "w not zero on pass-through")
   // After a divide w is the clamped constant one.
   `HVT_ASSERT_IMPLY(a_div_w, rsp_valid_ff && rsp_was_divided_ff, rsp_out_w_ff == ONE_VAL, "w not one after divide")

endmodule

// ===== verif/homogeneous_vertex_transform_test.sv =====
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_test
// Self-checking testbench for the vertex transform. A directed table runs on
// the identity matrix after reset, then random vertices run through several
// matrix settings. Every result is compared with the table's expectation or a predictor written here.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_test;

   localparam int FRAC       = hvt_pkg::FRAC_BITS_DEF;
   localparam int ONE_Q      = 1 << FRAC;
   localparam int PHASES     = 7;
   localparam int PHASE_ITEMS = 250;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 30;

   typedef struct {
      logic signed [hvt_pkg::FIELD_W-1:0] x, y, z, w;
      bit                                 divided;
      bit                                 saturated;
   } projected_vertex_type;

   typedef struct {
      logic signed [hvt_pkg::FIELD_W-1:0] x, y, z, w;
      bit                                 known;
      projected_vertex_type               want;
   } directed_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [hvt_pkg::FIELD_W-1:0]  req_in_x = '0, req_in_y = '0;
   logic signed [hvt_pkg::FIELD_W-1:0]  req_in_z = '0, req_in_w = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [hvt_pkg::FIELD_W-1:0]  rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic                                rsp_was_divided, rsp_saturated;
   logic                                csr_wr_en = 1'b0;
   logic [hvt_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [hvt_pkg::ROW_W-1:0]           csr_wdata = '0;

   logic [hvt_pkg::ROW_W-1:0]           matrix_rows [hvt_pkg::NUM_ROWS];
   projected_vertex_type                pending_vertices [$];
   bit                                  idling = 1'b1;
   bit                                  row_known = 1'b0;
   projected_vertex_type                row_want;
   int                                  mismatches = 0;
   int                                  quiet_cycles = 0;

   homogeneous_vertex_transform DUT (.*);

   always #5 clock = ~clock;

   // Saturate to the signed component range and note any clamping.
   function automatic longint clamp_component(input longint v, inout bit sat);
      if (v > 32767) begin
         sat = 1'b1;
         return 32767;
      end
      if (v < -32768) begin
         sat = 1'b1;
         return -32768;
      end
      return v;
   endfunction

   // Matrix times vector, then the perspective divide when the w sum is nonzero.
   function automatic projected_vertex_type project_vertex(
      input logic signed [hvt_pkg::FIELD_W-1:0] x, y, z, w);
      logic signed [hvt_pkg::FIELD_W-1:0] vec [hvt_pkg::NUM_COLS];
      logic signed [hvt_pkg::FIELD_W-1:0] coeff;
      longint                             acc [hvt_pkg::NUM_ROWS];
      longint                             res [hvt_pkg::NUM_ROWS];
      projected_vertex_type               p;
      bit                                 sat;
      sat = 1'b0;
      vec[0] = x; vec[1] = y; vec[2] = z; vec[3] = w;
      for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
         acc[r] = 0;
         for (int c = 0; c < hvt_pkg::NUM_COLS; c++) begin
            coeff = matrix_rows[r][hvt_pkg::FIELD_W*c +: hvt_pkg::FIELD_W];
            acc[r] += longint'(coeff) * longint'(vec[c]);
         end
      end
      p.divided = (acc[3] != 0);
      if (p.divided) begin
         for (int r = 0; r < 3; r++)
            res[r] = clamp_component((acc[r] * ONE_Q) / acc[3], sat);
         res[3] = clamp_component(ONE_Q, sat);
      end else begin
         for (int r = 0; r < hvt_pkg::NUM_ROWS; r++)
            res[r] = clamp_component(acc[r] >>> FRAC, sat);
      end
      p.x = hvt_pkg::FIELD_W'(res[0]);
      p.y = hvt_pkg::FIELD_W'(res[1]);
      p.z = hvt_pkg::FIELD_W'(res[2]);
      p.w = hvt_pkg::FIELD_W'(res[3]);
      p.saturated = sat;
      return p;
   endfunction

   // Matrix used by each random phase; all four rows are always written.
   function automatic logic [hvt_pkg::ROW_W-1:0] phase_row(input int phase, input int r);
      logic [hvt_pkg::ROW_W-1:0] v;
      v = {$urandom, $urandom};
      case (phase)
         1: ;
         2: for (int c = 0; c < hvt_pkg::NUM_COLS; c++)
               v[hvt_pkg::FIELD_W*c +: hvt_pkg::FIELD_W] =
                  hvt_pkg::FIELD_W'($urandom_range(1024) - 512);
         3: v = {hvt_pkg::NUM_COLS{16'h7FFF}};
         4: v = {hvt_pkg::NUM_COLS{16'h8000}};
         5: if (r == 3) v = '0;
         6: begin
            v = '0;
            v[hvt_pkg::FIELD_W*r +: hvt_pkg::FIELD_W] = 16'h0100;
            if (r == 3)
               v[hvt_pkg::FIELD_W*3 +: hvt_pkg::FIELD_W] =
                  hvt_pkg::FIELD_W'($urandom_range(1023) + 1);
         end
         default: v = {hvt_pkg::NUM_COLS{16'hFFFF}};
      endcase
      return v;
   endfunction

   function automatic logic signed [hvt_pkg::FIELD_W-1:0] random_component();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) return hvt_pkg::FIELD_W'($urandom);
      if (pick < 80) return hvt_pkg::FIELD_W'($urandom_range(2048) - 1024);
      case ($urandom_range(4))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sd0;
         3: return -16'sd1;
         default: return 16'sd1;
      endcase
   endfunction

   task automatic write_row(input hvt_pkg::csr_index_type idx,
                            input logic [hvt_pkg::ROW_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      matrix_rows[idx] = data;
      csr_wr_en <= 1'b0;
   endtask

   // One vertex transfer, with a random gap ahead of it while idling is on.
   task automatic send_vertex(input logic signed [hvt_pkg::FIELD_W-1:0] x, y, z, w);
      while (idling && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_x <= x; req_in_y <= y; req_in_z <= z; req_in_w <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Expectation is recorded at the edge of each input transfer.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         pending_vertices.push_back(row_known ? row_want :
                                    project_vertex(req_in_x, req_in_y, req_in_z, req_in_w));
   end

   // Result side: random stalls, and each transfer checked against the oldest expectation.
   always @(posedge clock) begin
      projected_vertex_type e;
      rsp_ready <= !reset && (!idling || $urandom_range(99) >= 38);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result x=%0d", rsp_out_x);
         end else begin
            e = pending_vertices.pop_front();
            if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_z !== e.z ||
                rsp_out_w !== e.w || rsp_was_divided !== e.divided ||
                rsp_saturated !== e.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want %0d %0d %0d %0d d%0b s%0b got %0d %0d %0d %0d d%0b s%0b",
                           e.x, e.y, e.z, e.w, e.divided, e.saturated, rsp_out_x,
                           rsp_out_y, rsp_out_z, rsp_out_w, rsp_was_divided, rsp_saturated);
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("homogeneous_vertex_transform verification failed");
         $finish;
      end
   end

   initial begin
      directed_row_type directed_rows [] = '{
         '{0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0}},
         '{256, 512, -256, 256, 1, '{256, 512, -256, 256, 1, 0}},
         '{-32768, 32767, -1, 0, 1, '{-32768, 32767, -1, 0, 0, 0}},
         '{32767, 0, 0, 1, 1, '{32767, 0, 0, 256, 1, 1}},
         '{-32768, 0, 0, 1, 1, '{-32768, 0, 0, 256, 1, 1}},
         '{1, -1, 0, 768, 1, '{0, 0, 0, 256, 1, 0}},
         '{256, -512, 768, -256, 1, '{-256, 512, -768, 256, 1, 0}},
         '{0, 0, 0, -32768, 1, '{0, 0, 0, 256, 1, 0}},
         '{32767, 32767, 32767, 32767, 1, '{256, 256, 256, 256, 1, 0}},
         '{-32768, -32768, -32768, 32767, 1, '{-256, -256, -256, 256, 1, 0}},
         '{-1, -1, -1, -1, 1, '{256, 256, 256, 256, 1, 0}},
         '{123, -4567, 890, -12, 0, '{0, 0, 0, 0, 0, 0}},
         '{-300, 7, 32767, 0, 0, '{0, 0, 0, 0, 0, 0}},
         '{5, 3, -2, 3, 0, '{0, 0, 0, 0, 0, 0}}
      };
      matrix_rows[0] = hvt_pkg::ROW0_RESET;
      matrix_rows[1] = hvt_pkg::ROW1_RESET;
      matrix_rows[2] = hvt_pkg::ROW2_RESET;
      matrix_rows[3] = hvt_pkg::ROW3_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows on the identity matrix left by reset. The expectation
      // changes after the edge so the previous transfer keeps its own row.
      foreach (directed_rows[i]) begin
         row_known <= directed_rows[i].known;
         row_want  <= directed_rows[i].want;
         send_vertex(directed_rows[i].x, directed_rows[i].y,
                     directed_rows[i].z, directed_rows[i].w);
      end
      row_known <= 1'b0;
      wait_drained();

      // Random phases, each with its own matrix; one phase runs with no idling.
      for (int phase = 1; phase <= PHASES; phase++) begin
         write_row(hvt_pkg::CSR_ROW0, phase_row(phase, 0));
         write_row(hvt_pkg::CSR_ROW1, phase_row(phase, 1));
         write_row(hvt_pkg::CSR_ROW2, phase_row(phase, 2));
         write_row(hvt_pkg::CSR_ROW3, phase_row(phase, 3));
         idling = (phase != 4);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_vertex(random_component(), random_component(),
                        random_component(), $urandom_range(9) == 0 ? 16'sd0 : random_component());
         wait_drained();
      end

      if (mismatches == 0 && pending_vertices.size() == 0)
         $display("homogeneous_vertex_transform verification clean");
      else
         $display("homogeneous_vertex_transform verification failed");
      $finish;
   end

endmodule
